/* hw/rtl/gtbp_pkg.sv */
package gtbp_pkg;

  // default coordinate width and fixed width of the result fields
  localparam int unsigned POS_WIDTH_DEF = 16;
  localparam int unsigned OUT_WIDTH     = 16;

  // prefix run counter
  localparam int unsigned CNT_WIDTH = 6;
  localparam logic [CNT_WIDTH-1:0] RUN_MAX = 6'd63;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_START_POS = 1'b0,
    CFG_EXTENT    = 1'b1
  } cfg_idx_e;

  // one result beat
  typedef struct packed {
    logic [OUT_WIDTH-1:0] position;
    logic [OUT_WIDTH-1:0] range_low;
    logic [OUT_WIDTH-1:0] range_high;
    logic                 bisecting;
  } result_t;

endpackage

/* hw/rtl/gallop_then_bisect_position_core.sv */
// Search-position engine: each direction beat (0 forwards, 1 backwards) yields one result beat.
// A session opens on first_i (or on any beat after reset), nudges start_position one step and
// gallops by 4*(2^p-1) while the direction repeats, saturating at 0 or extent_limit; the first
// opposite beat fixes a range between the last two gallop targets, and every later beat halves
// that range toward its direction, the position being the floor midpoint. Throughput is one beat
// per cycle while in_stall_o is low: all work is one pass through two jump units and a midpoint
// adder, and the result is registered on acceptance. A two-entry output buffer decouples the
// sides, so in_stall_o is a register and rises only when two results are waiting.
// Configuration writes (index 0 start_position, 1 extent_limit) are taken every cycle;
// start_position is sampled when a session opens, extent_limit is read live. No clearing pass.
module gallop_then_bisect_position_core #(
  parameter int unsigned POS_WIDTH = gtbp_pkg::POS_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [POS_WIDTH-1:0]           cfg_wdata_i,
  // decision beats
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           direction_i,
  input  logic                           first_i,
  // result beats
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gtbp_pkg::OUT_WIDTH-1:0] position_o,
  output logic [gtbp_pkg::OUT_WIDTH-1:0] range_low_o,
  output logic [gtbp_pkg::OUT_WIDTH-1:0] range_high_o,
  output logic                           bisecting_o
);

  localparam int unsigned W  = POS_WIDTH;
  localparam int unsigned CW = gtbp_pkg::CNT_WIDTH;
  localparam int unsigned OW = gtbp_pkg::OUT_WIDTH;

  // configuration registers
  logic [W-1:0] start_q, extent_q;

  // session state
  logic          init_dir_q, init_dir_d;
  logic [CW-1:0] run_q, run_d;
  logic          tail_q, tail_d;
  logic [W-1:0]  adj_q, adj_d;
  logic [W-1:0]  lo_q, lo_d;
  logic [W-1:0]  hi_q, hi_d;

  // output buffer
  logic                 out_valid_q, out_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  gtbp_pkg::result_t    out_q, out_d;
  gtbp_pkg::result_t    skid_q, skid_d;
  gtbp_pkg::result_t    res;

  logic accept, pop;

  // datapath
  logic          new_sess, gallop;
  logic [W-1:0]  nudged;
  logic [CW-1:0] run_inc;
  logic [W-1:0]  ja_start;
  logic          ja_dir;
  logic [CW-1:0] ja_run;
  logic [W-1:0]  ja, jb;
  logic [W:0]    mid_sum, pos_sum;
  logic [W-1:0]  mid, pos;
  logic          bis;

  assign accept = in_valid_i && !skid_valid_q;
  assign pop    = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      extent_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gtbp_pkg::CFG_START_POS: start_q  <= cfg_wdata_i;
        gtbp_pkg::CFG_EXTENT:    extent_q <= cfg_wdata_i;
      endcase
    end
  end

  // session opens on first, or on any beat while no run is open
  assign new_sess = first_i || (run_q == '0);
  assign gallop   = !tail_q && (direction_i == init_dir_q);
  assign run_inc  = (run_q == gtbp_pkg::RUN_MAX) ? run_q : run_q + CW'(1);

  always_comb begin
    if (!direction_i) begin
      nudged = (start_q < extent_q) ? start_q + W'(1) : start_q;
    end else begin
      nudged = (start_q != '0) ? start_q - W'(1) : start_q;
    end
  end

  // unit a: current gallop target (run p), unit b: previous one (run p-1)
  assign ja_start = new_sess ? nudged : adj_q;
  assign ja_dir   = new_sess ? direction_i : init_dir_q;
  assign ja_run   = new_sess ? CW'(1) : (gallop ? run_inc : run_q);

  gtbp_jump #(.POS_WIDTH(W)) u_jump_cur (
    .start_i  (ja_start),
    .extent_i (extent_q),
    .dir_i    (ja_dir),
    .run_i    (ja_run),
    .target_o (ja)
  );

  gtbp_jump #(.POS_WIDTH(W)) u_jump_prev (
    .start_i  (adj_q),
    .extent_i (extent_q),
    .dir_i    (init_dir_q),
    .run_i    (run_q - CW'(1)),
    .target_o (jb)
  );

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[W:1];

  always_comb begin
    init_dir_d = init_dir_q;
    run_d      = run_q;
    tail_d     = tail_q;
    adj_d      = adj_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    bis        = 1'b0;
    if (new_sess) begin
      init_dir_d = direction_i;
      run_d      = CW'(1);
      tail_d     = 1'b0;
      adj_d      = nudged;
      lo_d       = ja;
      hi_d       = ja;
    end else if (gallop) begin
      run_d = run_inc;
      lo_d  = ja;
      hi_d  = ja;
    end else if (!tail_q) begin
      // first opposite beat: range between the last two targets
      tail_d = 1'b1;
      bis    = 1'b1;
      lo_d   = (ja < jb) ? ja : jb;
      hi_d   = (ja < jb) ? jb : ja;
    end else begin
      bis = 1'b1;
      if (!direction_i) begin
        lo_d = mid;
      end else begin
        hi_d = mid;
      end
    end
  end

  assign pos_sum = {1'b0, lo_d} + {1'b0, hi_d};
  assign pos     = bis ? pos_sum[W:1] : lo_d;

  always_comb begin
    res.position   = OW'(pos);
    res.range_low  = OW'(lo_d);
    res.range_high = OW'(hi_d);
    res.bisecting  = bis;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_dir_q <= 1'b0;
      run_q      <= '0;
      tail_q     <= 1'b0;
      adj_q      <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
    end else if (accept) begin
      init_dir_q <= init_dir_d;
      run_q      <= run_d;
      tail_q     <= tail_d;
      adj_q      <= adj_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
    end
  end

  // two-entry output buffer: head register plus skid register
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = accept;
      end
    end else if (accept) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o   = skid_valid_q;
  assign out_valid_o  = out_valid_q;
  assign position_o   = out_q.position;
  assign range_low_o  = out_q.range_low;
  assign range_high_o = out_q.range_high;
  assign bisecting_o  = out_q.bisecting;

endmodule

/* hw/rtl/gtbp_jump.sv */
module gtbp_jump #(
  parameter int unsigned POS_WIDTH = gtbp_pkg::POS_WIDTH_DEF
) (
  input  logic [POS_WIDTH-1:0]           start_i,
  input  logic [POS_WIDTH-1:0]           extent_i,
  input  logic                           dir_i,
  input  logic [gtbp_pkg::CNT_WIDTH-1:0] run_i,
  output logic [POS_WIDTH-1:0]           target_o
);

  localparam int unsigned CW = gtbp_pkg::CNT_WIDTH;

  logic                 big;
  logic [POS_WIDTH:0]   one_hot;
  logic [POS_WIDTH:0]   total_w;
  logic [POS_WIDTH-1:0] total;
  logic [POS_WIDTH-1:0] room;
  logic                 fwd_sat;

  // jump of 4*(2^p-1) reaches past any coordinate once p >= width-1
  assign big     = (run_i >= CW'(POS_WIDTH - 1));
  assign one_hot = (POS_WIDTH + 1)'(1) << run_i;
  assign total_w = (one_hot << 2) - (POS_WIDTH + 1)'(4);
  assign total   = total_w[POS_WIDTH-1:0];
  assign room    = extent_i - start_i;
  assign fwd_sat = big || (start_i >= extent_i) || (room <= total);

  always_comb begin
    if (!dir_i) begin
      target_o = fwd_sat ? extent_i : start_i + total;
    end else if (!big && (start_i >= total)) begin
      target_o = start_i - total;
    end else begin
      target_o = '0;
    end
  end

endmodule

/* hw/rtl/gtbp_checker.sv */
module gtbp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [gtbp_pkg::OUT_WIDTH-1:0] position_o,
  input logic [gtbp_pkg::OUT_WIDTH-1:0] range_low_o,
  input logic [gtbp_pkg::OUT_WIDTH-1:0] range_high_o,
  input logic                           bisecting_o
);

  localparam int unsigned OW = gtbp_pkg::OUT_WIDTH;

  logic [OW:0] sum;
  assign sum = {1'b0, range_low_o} + {1'b0, range_high_o};

  // range ends are ordered
  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (range_low_o <= range_high_o))
    else $error("range ends out of order");

  // while galloping the range collapses onto the position
  a_gallop_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !bisecting_o) |->
      (range_low_o == position_o) && (range_high_o == position_o))
    else $error("gallop beat with open range");

  // while bisecting the position is the floor midpoint
  a_bisect_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bisecting_o) |-> (position_o == sum[OW:1]))
    else $error("bisect position not the midpoint");

  // input stalls only while a result beat is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(position_o) && $stable(range_low_o) &&
       $stable(range_high_o) && $stable(bisecting_o)))
    else $error("stalled result beat changed");

endmodule

bind gallop_then_bisect_position_core gtbp_checker u_gtbp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .position_o   (position_o),
  .range_low_o  (range_low_o),
  .range_high_o (range_high_o),
  .bisecting_o  (bisecting_o)
);

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  // runs longer than this go straight to 0 or to the extent limit
  localparam int unsigned GIVE_UP_RUN = 60;
  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_BWD = 1'b1;

  typedef struct packed {
    logic dir;
    logic first;
  } decision_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  // configuration port
  logic        cfg_we_i    = 1'b0;
  logic [0:0]  cfg_idx_i   = gtbp_pkg::CFG_START_POS;
  logic [15:0] cfg_wdata_i = '0;

  // decision side
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  logic direction_i = 1'b0;
  logic first_i     = 1'b0;

  // result side
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [gtbp_pkg::OUT_WIDTH-1:0] position_o;
  logic [gtbp_pkg::OUT_WIDTH-1:0] range_low_o;
  logic [gtbp_pkg::OUT_WIDTH-1:0] range_high_o;
  logic                           bisecting_o;

  gallop_then_bisect_position_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .direction_i  (direction_i),
    .first_i      (first_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .position_o   (position_o),
    .range_low_o  (range_low_o),
    .range_high_o (range_high_o),
    .bisecting_o  (bisecting_o)
  );

  // decisions waiting to be sent, head is the one on the bus
  decision_t decisions[$];
  // cursor results still owed by the block, oldest first
  gtbp_pkg::result_t cursor_results[$];

  int unsigned mismatches     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_off       = 1'b0;

  // shadow of the registers
  logic [15:0] start_pos = '0;
  logic [15:0] extent    = '0;

  // shadow of the search state
  logic        lead_dir  = 1'b0;
  logic [5:0]  run_count = '0;
  logic        halving   = 1'b0;
  logic [15:0] base_pos  = '0;
  logic [15:0] lo_end    = '0;
  logic [15:0] hi_end    = '0;

  // target of a gallop of p steps, jump worked out in 64 bits so it never wraps
  function automatic logic [15:0] gallop_target(input logic [15:0] base,
                                                input logic [15:0] limit,
                                                input logic dir, input logic [5:0] p);
    logic [63:0] jump;
    if (p > GIVE_UP_RUN) return (dir == DIR_BWD) ? 16'd0 : limit;
    jump = (64'd4 << p) - 64'd4;
    if (dir == DIR_FWD) begin
      if (base >= limit || (64'(limit) - 64'(base)) <= jump) return limit;
      return base + jump[15:0];
    end
    return (64'(base) >= jump) ? base - jump[15:0] : 16'd0;
  endfunction

  // moves the shadow cursor by one decision and queues the result it owes
  task automatic advance_cursor(input logic dir, input logic first);
    logic [15:0]       s, a, b, mid;
    gtbp_pkg::result_t r;
    if (first || run_count == 0) begin
      // new session, a beat without first also opens one right after reset
      s = start_pos;
      lead_dir  = dir;
      run_count = 6'd1;
      halving   = 1'b0;
      if (dir == DIR_FWD) begin
        if (s < extent) s = s + 16'd1;
      end else if (s != 0) begin
        s = s - 16'd1;
      end
      base_pos = s;
      lo_end = gallop_target(base_pos, extent, dir, run_count);
      hi_end = lo_end;
    end else if (!halving && dir == lead_dir) begin
      // still galloping, counter sticks at its top
      if (run_count < gtbp_pkg::RUN_MAX) run_count = run_count + 6'd1;
      lo_end = gallop_target(base_pos, extent, dir, run_count);
      hi_end = lo_end;
    end else if (!halving) begin
      // first turn: range spans the last two gallop targets
      a = gallop_target(base_pos, extent, lead_dir, run_count);
      b = gallop_target(base_pos, extent, lead_dir, run_count - 6'd1);
      halving = 1'b1;
      lo_end = (a < b) ? a : b;
      hi_end = (a < b) ? b : a;
    end else begin
      mid = 16'(({1'b0, lo_end} + {1'b0, hi_end}) >> 1);
      if (dir == DIR_FWD) lo_end = mid;
      else hi_end = mid;
    end
    r.range_low  = lo_end;
    r.range_high = hi_end;
    r.position   = 16'(({1'b0, lo_end} + {1'b0, hi_end}) >> 1);
    r.bisecting  = halving;
    cursor_results.push_back(r);
  endtask

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    mismatches++;
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  task automatic check_result();
    gtbp_pkg::result_t want;
    if (cursor_results.size() == 0) begin
      flag_mismatch("result beat with nothing pending, position", position_o, 16'd0);
      return;
    end
    want = cursor_results.pop_front();
    if (position_o !== want.position) flag_mismatch("position", position_o, want.position);
    if (range_low_o !== want.range_low)
      flag_mismatch("range_low", range_low_o, want.range_low);
    if (range_high_o !== want.range_high)
      flag_mismatch("range_high", range_high_o, want.range_high);
    if (bisecting_o !== want.bisecting)
      flag_mismatch("bisecting", 16'(bisecting_o), 16'(want.bisecting));
  endtask

  // driver: head of the queue leaves only when the beat is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        advance_cursor(direction_i, first_i);
        void'(decisions.pop_front());
      end
      // a stalled beat stays put, otherwise offer the next one or idle
      if (!(in_valid_i && in_stall_o)) begin
        if (decisions.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i  <= 1'b1;
          direction_i <= decisions[0].dir;
          first_i     <= decisions[0].first;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks taken result beats and drives the stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_result();
      if (hold_off) begin
        // long hold-off so the output buffer fills and the input backs up
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic write_reg(input gtbp_pkg::cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gtbp_pkg::CFG_START_POS) start_pos = val;
    else extent = val;
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'hffff;
      2:       return 16'($urandom_range(0, 300));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic queue_beat(input logic d, input logic f);
    decision_t item;
    item.dir   = d;
    item.first = f;
    decisions.push_back(item);
  endtask

  task automatic queue_run(input logic d, input int unsigned n);
    repeat (n) queue_beat(d, 1'b0);
  endtask

  // mostly whole sessions: open, gallop, turn, halve; some noise and cut-short ones
  task automatic queue_sessions(input int unsigned count);
    int unsigned made, run_len, tail_len;
    logic        d;
    // a few beats that carry on whatever session was left open
    made = $urandom_range(0, 3);
    repeat (made) queue_beat(1'($urandom_range(1)), 1'b0);
    while (made < count) begin
      if ($urandom_range(9) == 0) begin
        queue_beat(1'($urandom_range(1)), 1'($urandom_range(1)));
        made++;
      end else begin
        d        = 1'($urandom_range(1));
        run_len  = ($urandom_range(19) == 0) ? $urandom_range(58, 66) : $urandom_range(0, 10);
        tail_len = $urandom_range(0, 18);
        queue_beat(d, 1'b1);
        queue_run(d, run_len);
        made += 1 + run_len;
        // sometimes the session is dropped before it turns
        if ($urandom_range(7) != 0) begin
          queue_beat(~d, 1'b0);
          repeat (tail_len) queue_beat(1'($urandom_range(1)), 1'b0);
          made += 1 + tail_len;
        end
      end
    end
  endtask

  // lets everything drain, then waits for the pipeline to settle
  task automatic drain();
    while (decisions.size() != 0 || cursor_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                              input int unsigned count);
    write_reg(gtbp_pkg::CFG_START_POS, pick_coord());
    write_reg(gtbp_pkg::CFG_EXTENT, pick_coord());
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    queue_sessions(count);
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: session opened without first, gallop, turn, halving both ways
    write_reg(gtbp_pkg::CFG_START_POS, 16'd100);
    write_reg(gtbp_pkg::CFG_EXTENT, 16'd1000);
    queue_beat(DIR_FWD, 1'b0);
    queue_run(DIR_FWD, 3);
    queue_beat(DIR_BWD, 1'b0);
    queue_beat(DIR_FWD, 1'b0);
    queue_run(DIR_BWD, 2);
    queue_beat(DIR_BWD, 1'b1);
    queue_run(DIR_BWD, 2);
    queue_beat(DIR_FWD, 1'b0);
    queue_beat(DIR_BWD, 1'b0);
    // forward gallop running into the extent
    queue_beat(DIR_FWD, 1'b1);
    queue_run(DIR_FWD, 8);
    queue_beat(DIR_BWD, 1'b0);
    queue_beat(DIR_FWD, 1'b0);
    drain();

    // extent changed mid-session: carry on galloping against the new limit
    write_reg(gtbp_pkg::CFG_EXTENT, 16'd300);
    queue_beat(DIR_FWD, 1'b1);
    queue_run(DIR_FWD, 2);
    drain();
    write_reg(gtbp_pkg::CFG_EXTENT, 16'd40);
    queue_run(DIR_FWD, 1);
    queue_beat(DIR_BWD, 1'b0);
    drain();

    // both registers at the top
    write_reg(gtbp_pkg::CFG_START_POS, 16'hffff);
    write_reg(gtbp_pkg::CFG_EXTENT, 16'hffff);
    queue_beat(DIR_FWD, 1'b1);
    queue_run(DIR_FWD, 2);
    queue_beat(DIR_BWD, 1'b0);
    queue_beat(DIR_BWD, 1'b1);
    queue_run(DIR_BWD, 2);
    queue_beat(DIR_FWD, 1'b0);
    queue_beat(DIR_FWD, 1'b0);
    drain();

    // start beyond extent
    write_reg(gtbp_pkg::CFG_START_POS, 16'd60000);
    write_reg(gtbp_pkg::CFG_EXTENT, 16'd100);
    queue_beat(DIR_FWD, 1'b1);
    queue_run(DIR_FWD, 1);
    queue_beat(DIR_BWD, 1'b0);
    queue_beat(DIR_BWD, 1'b1);
    queue_run(DIR_BWD, 1);
    queue_beat(DIR_FWD, 1'b0);
    drain();

    // both registers at zero
    write_reg(gtbp_pkg::CFG_START_POS, 16'd0);
    write_reg(gtbp_pkg::CFG_EXTENT, 16'd0);
    queue_beat(DIR_FWD, 1'b1);
    queue_beat(DIR_BWD, 1'b1);
    queue_run(DIR_BWD, 1);
    queue_beat(DIR_FWD, 1'b0);
    drain();

    // random sessions under each idling pattern
    random_phase(0, 0, 170);
    random_phase(78, 0, 170);
    random_phase(0, 78, 170);
    random_phase(25, 25, 170);

    // back-pressure: sender flat out while the receiver holds off
    write_reg(gtbp_pkg::CFG_START_POS, pick_coord());
    write_reg(gtbp_pkg::CFG_EXTENT, pick_coord());
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    // hold-off length counted in its own process
    fork
      begin
        hold_off <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join_none
    queue_sessions(120);
    drain();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* gallop_then_bisect_position_core.f */
hw/rtl/gtbp_pkg.sv
hw/rtl/gtbp_jump.sv
hw/rtl/gallop_then_bisect_position_core.sv
hw/rtl/gtbp_checker.sv
test/tb_top.sv
